@@ src/ita_pkg.sv @@
// Package for the integer-to-ASCII formatter: constants, types and the BCD step function.
`default_nettype none
package ita_pkg;

    localparam int WORD_WIDTH     = 32;
    localparam int BITS_PER_STAGE = 8;
    localparam int NUM_STAGES     = WORD_WIDTH / BITS_PER_STAGE;
    // Decimal digits needed for a WORD_WIDTH-bit magnitude (log10(2) rounded down to 0.3).
    localparam int BCD_DIGITS     = (WORD_WIDTH * 3) / 10 + 1;
    localparam int BCD_W          = BCD_DIGITS * 4;
    localparam int POS_W          = $clog2(WORD_WIDTH);
    localparam int DIG_W          = $clog2(BCD_DIGITS);
    localparam int CHAR_W         = 7;
    localparam int LEN_W          = 6;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;

    typedef enum logic {
        MODE_DEC = 1'b0,
        MODE_BIN = 1'b1
    } mode_t;

    // Payload carried down the conversion pipeline.
    typedef struct packed {
        mode_t                 mode;
        logic                  neg;
        logic [WORD_WIDTH-1:0] mag;   // magnitude, kept for binary output
        logic [WORD_WIDTH-1:0] shf;   // bits not yet folded into bcd, MSB first
        logic [BCD_W-1:0]      bcd;
    } item_t;

    // Double dabble over BITS_PER_STAGE input bits, MSB first.
    function automatic logic [BCD_W-1:0] dabble_step(
        input logic [BCD_W-1:0]          bcd_in,
        input logic [BITS_PER_STAGE-1:0] bits
    );
        logic [BCD_W-1:0] acc;
        acc = bcd_in;
        for (int b = BITS_PER_STAGE - 1; b >= 0; b--) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (acc[d*4 +: 4] >= 4'd5) begin
                    acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[b]};
        end
        return acc;
    endfunction

endpackage
`default_nettype wire

@@ src/ita_in_if.sv @@
// Input channel: one word and its print mode per transaction.
`default_nettype none
interface ita_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [ita_pkg::WORD_WIDTH-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface
`default_nettype wire

@@ src/ita_out_if.sv @@
// Output channel: one ASCII character per transaction.
`default_nettype none
interface ita_out_if;
    logic                       valid;
    logic                       ready;
    logic [ita_pkg::CHAR_W-1:0] character;
    logic                       last;
    logic [ita_pkg::LEN_W-1:0]  length;

    modport source (output valid, output character, output last, output length, input ready);
    modport sink   (input valid, input character, input last, input length, output ready);
endinterface
`default_nettype wire

@@ src/integer_to_ascii_formatter.sv @@
// Top level of the integer-to-ASCII formatter: input register, BCD pipeline, serializer.
`default_nettype none
//
//  channel   | dir | payload                         | handshake
//  ----------+-----+---------------------------------+------------------
//  in_chan   | in  | mode (1), value (32)            | valid/ready
//  out_chan  | out | character (7), last, length (6) | valid/ready
//
// Pipeline: input register (sign/magnitude), four double-dabble stages of
// eight bits each, then the serializer.
// Each word holds the output port until all of its characters (1 to 32)
// have transferred: the serializer sends one character per cycle while
// out_chan is ready, and it takes the next word on the transfer of the
// current word's last character.
// Reset clears only the valid bits of each stage and the serializer's busy
// flag. A stall on out_chan freezes each full stage in place; stages with
// a hole keep filling, so words queue up to six deep.
module integer_to_ascii_formatter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ita_in_if.sink     in_chan,
    ita_out_if.source  out_chan
);

    localparam int NS = ita_pkg::NUM_STAGES;

    logic [NS:0]    stage_valid;
    logic [NS:0]    stage_ready;
    ita_pkg::item_t stage_item [NS+1];
    logic           ser_ready;

    // ---------------- input register: sign and magnitude ----------------
    logic           in_valid_reg, in_valid_next;
    ita_pkg::item_t in_item_reg,  in_item_next;
    logic           in_neg;

    // Negation is done in WORD_WIDTH bits unsigned, so the most negative
    // value yields its true magnitude.
    assign in_neg = (ita_pkg::mode_t'(in_chan.mode) == ita_pkg::MODE_DEC)
                    && in_chan.value[ita_pkg::WORD_WIDTH-1];

    assign in_chan.ready = !in_valid_reg || stage_ready[0];

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (in_chan.ready)
        begin
            in_valid_next     = in_chan.valid;
            in_item_next.mode = ita_pkg::mode_t'(in_chan.mode);
            in_item_next.neg  = in_neg;
            in_item_next.mag  = in_neg ? (~in_chan.value + ita_pkg::WORD_WIDTH'(1))
                                       : in_chan.value;
            in_item_next.shf  = in_neg ? (~in_chan.value + ita_pkg::WORD_WIDTH'(1))
                                       : in_chan.value;
            in_item_next.bcd  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    assign stage_valid[0] = in_valid_reg;
    assign stage_item[0]  = in_item_reg;

    // ---------------- double-dabble pipeline ----------------
    for (genvar s = 0; s < NS; s++)
    begin : g_bcd
        ita_bcd_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[s]),
            .up_ready (stage_ready[s]),
            .up_item  (stage_item[s]),
            .dn_valid (stage_valid[s+1]),
            .dn_ready (stage_ready[s+1]),
            .dn_item  (stage_item[s+1])
        );
    end

    assign stage_ready[NS] = ser_ready;

    // ---------------- output serializer ----------------
    ita_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stage_valid[NS]),
        .up_ready (ser_ready),
        .up_item  (stage_item[NS]),
        .out_chan (out_chan)
    );

    // ---------------- assertions ----------------
    // A minus sign always has digits after it.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_chan.valid && (out_chan.character == ita_pkg::CHAR_MINUS) |-> !out_chan.last)
        else $error("minus sign flagged as last character");

    // Every other character is a decimal or binary digit.
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_chan.valid && (out_chan.character != ita_pkg::CHAR_MINUS)
        |-> (out_chan.character >= ita_pkg::CHAR_ZERO)
            && (out_chan.character <= ita_pkg::CHAR_NINE))
        else $error("character outside digit range");

    // A word that is still being emitted keeps its length.
    a_length_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_chan.valid && out_chan.ready && !out_chan.last
        |=> out_chan.valid && (out_chan.length == $past(out_chan.length)))
        else $error("length changed inside a string");

endmodule
`default_nettype wire

@@ src/ita_bcd_stage.sv @@
// One pipeline stage of the binary-to-BCD conversion (one byte of double dabble).
`default_nettype none
module ita_bcd_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire ita_pkg::item_t up_item,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output ita_pkg::item_t      dn_item
);

    logic           valid_reg;
    logic           valid_next;
    ita_pkg::item_t item_reg;
    ita_pkg::item_t item_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (up_ready)
        begin
            valid_next    = up_valid;
            item_next     = up_item;
            item_next.bcd = ita_pkg::dabble_step(
                up_item.bcd,
                up_item.shf[ita_pkg::WORD_WIDTH-1 -: ita_pkg::BITS_PER_STAGE]);
            item_next.shf = up_item.shf << ita_pkg::BITS_PER_STAGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule
`default_nettype wire

@@ src/ita_serializer.sv @@
// Character serializer: finds the string length and emits one character per transaction.
`default_nettype none
module ita_serializer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire ita_pkg::item_t up_item,
    ita_out_if.source           out_chan
);

    logic                            busy_reg,  busy_next;
    logic                            sign_reg,  sign_next;
    ita_pkg::mode_t                  mode_reg,  mode_next;
    logic [ita_pkg::WORD_WIDTH-1:0]  mag_reg,   mag_next;
    logic [ita_pkg::BCD_W-1:0]       bcd_reg,   bcd_next;
    logic [ita_pkg::POS_W-1:0]       pos_reg,   pos_next;
    logic [ita_pkg::LEN_W-1:0]       len_reg,   len_next;

    logic [ita_pkg::POS_W-1:0]       top;
    logic                            is_last;
    logic                            take;
    logic [3:0]                      digit;

    // Index of the most significant nonzero digit; zero prints one digit.
    always_comb
    begin
        top = '0;
        if (up_item.mode == ita_pkg::MODE_BIN)
        begin
            for (int i = 0; i < ita_pkg::WORD_WIDTH; i++)
            begin
                if (up_item.mag[i])
                begin
                    top = ita_pkg::POS_W'(i);
                end
            end
        end
        else
        begin
            for (int i = 0; i < ita_pkg::BCD_DIGITS; i++)
            begin
                if (up_item.bcd[i*4 +: 4] != 4'd0)
                begin
                    top = ita_pkg::POS_W'(i);
                end
            end
        end
    end

    assign is_last  = !sign_reg && (pos_reg == '0);
    assign take     = busy_reg && out_chan.ready;
    assign up_ready = !busy_reg || (take && is_last);

    always_comb
    begin
        busy_next = busy_reg;
        sign_next = sign_reg;
        mode_next = mode_reg;
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        pos_next  = pos_reg;
        len_next  = len_reg;
        if (take)
        begin
            if (sign_reg)
            begin
                sign_next = 1'b0;
            end
            else if (pos_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg - ita_pkg::POS_W'(1);
            end
        end
        if (up_ready && up_valid)
        begin
            busy_next = 1'b1;
            sign_next = up_item.neg;
            mode_next = up_item.mode;
            mag_next  = up_item.mag;
            bcd_next  = up_item.bcd;
            pos_next  = top;
            len_next  = ita_pkg::LEN_W'(top) + ita_pkg::LEN_W'(1)
                        + ita_pkg::LEN_W'(up_item.neg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        mode_reg <= mode_next;
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        pos_reg  <= pos_next;
        len_reg  <= len_next;
    end

    always_comb
    begin
        if (mode_reg == ita_pkg::MODE_BIN)
        begin
            digit = {3'b000, mag_reg[pos_reg]};
        end
        else
        begin
            digit = bcd_reg[pos_reg[ita_pkg::DIG_W-1:0]*4 +: 4];
        end
    end

    assign out_chan.valid     = busy_reg;
    assign out_chan.character = sign_reg ? ita_pkg::CHAR_MINUS
                                         : ita_pkg::CHAR_ZERO + ita_pkg::CHAR_W'(digit);
    assign out_chan.last      = is_last;
    assign out_chan.length    = len_reg;

endmodule
`default_nettype wire
